// ----- src/serial_frame_receiver_xor_check_defines.svh -----
// Assertion macros for the serial frame receiver.
// Included by the top level; no other dependencies.
`ifndef SERIAL_FRAME_RECEIVER_XOR_CHECK_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_XOR_CHECK_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/sfr_pkg.sv -----
// Types and constants for the serial frame receiver.
// No dependencies; used by every module of the block.
package sfr_pkg;

  typedef struct packed {
    logic [7:0] rx_data;
    logic       gap_before;
  } item_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  content_byte;
    logic [7:0]  content_index;
    logic [1:0]  frame_status;
    logic [1:0]  frame_class;
    logic [7:0]  msg_code;
    logic [15:0] body_length;
    logic [7:0]  frame_number;
    logic [3:0]  sequence_low;
    logic        first_of_message;
  } res_t;

  localparam logic [3:0] PH_HUNT      = 4'd0;
  localparam logic [3:0] PH_DISCARD   = 4'd1;
  localparam logic [3:0] PH_DEST      = 4'd2;
  localparam logic [3:0] PH_SRC       = 4'd3;
  localparam logic [3:0] PH_TYPE      = 4'd4;
  localparam logic [3:0] PH_LEN1      = 4'd5;
  localparam logic [3:0] PH_LEN2      = 4'd6;
  localparam logic [3:0] PH_BODY      = 4'd7;
  localparam logic [3:0] PH_ECHO_SRC  = 4'd8;
  localparam logic [3:0] PH_ECHO_TYPE = 4'd9;
  localparam logic [3:0] PH_ECHO_LEN1 = 4'd10;
  localparam logic [3:0] PH_ECHO_LEN2 = 4'd11;
  localparam logic [3:0] PH_ECHO_BODY = 4'd12;

  localparam logic       REC_CONTENT = 1'b0;
  localparam logic       REC_STATUS  = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  localparam logic [1:0] CLS_NORMAL = 2'd0;
  localparam logic [1:0] CLS_ACK    = 2'd1;
  localparam logic [1:0] CLS_LINK   = 2'd2;

  localparam logic [7:0] START_CABLE = 8'h1e;
  localparam logic [7:0] START_IR    = 8'h1c;
  localparam logic [7:0] ADDR_PHONE  = 8'h0c;
  localparam logic [7:0] ADDR_HOST   = 8'h00;
  localparam logic [7:0] TYPE_ACK    = 8'h7f;
  localparam logic [7:0] TYPE_LINK   = 8'hf1;

endpackage

// ----- src/serial_frame_receiver_xor_check.sv -----
// Top level of the serial frame receiver with two-lane XOR check.
// Depends on sfr_pkg, sfr_in_stage, sfr_parser, sfr_out_stage and the defines header.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_rx_data, in_gap_before
//   out      output     out_valid/out_ready  out_record_kind .. out_first_of_message
//   cfg      input      cfg_wr_en            cfg_wr_data (ir_mode)
//
// One byte a cycle while the output is not stalled; a result passes the input register, then the result register.
// The parser advances whenever the input register holds a byte and the result register is empty or being drained.
// rst_n is synchronous: parser back to hunting, both stages empty, ir_mode 0.
// A stalled output holds one result and one byte in the input register.
`include "serial_frame_receiver_xor_check_defines.svh"
module serial_frame_receiver_xor_check #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_data,
  input  logic        in_gap_before,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_kind,
  output logic [7:0]  out_content_byte,
  output logic [7:0]  out_content_index,
  output logic [1:0]  out_frame_status,
  output logic [1:0]  out_frame_class,
  output logic [7:0]  out_msg_code,
  output logic [15:0] out_body_length,
  output logic [7:0]  out_frame_number,
  output logic [3:0]  out_sequence_low,
  output logic        out_first_of_message
);
  import sfr_pkg::*;

  logic  ir_mode_r;
  item_t in_item, s1_item;
  logic  s1_valid, advance, emit;
  res_t  res, res_q;
  logic  content_clean, ack_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      ir_mode_r <= cfg_wr_data;
    end
  end

  assign in_item.rx_data    = in_rx_data;
  assign in_item.gap_before = in_gap_before;
  assign advance            = s1_valid && (!out_valid || out_ready);

  sfr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  sfr_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (s1_item),
    .ir_mode (ir_mode_r),
    .emit    (emit),
    .res     (res)
  );

  sfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_record_kind      = res_q.record_kind;
  assign out_content_byte     = res_q.content_byte;
  assign out_content_index    = res_q.content_index;
  assign out_frame_status     = res_q.frame_status;
  assign out_frame_class      = res_q.frame_class;
  assign out_msg_code         = res_q.msg_code;
  assign out_body_length      = res_q.body_length;
  assign out_frame_number     = res_q.frame_number;
  assign out_sequence_low     = res_q.sequence_low;
  assign out_first_of_message = res_q.first_of_message;

  assign content_clean = out_frame_status == ST_GOOD && out_frame_class == CLS_NORMAL &&
                         out_body_length == 16'd0;
  assign ack_status    = out_record_kind == REC_STATUS && out_msg_code == TYPE_ACK;

  `SFR_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `SFR_ASSERT_NOW(a_content_clean, clk, rst_n, out_valid && out_record_kind == REC_CONTENT, content_clean)
  `SFR_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_frame_status <= ST_OVERRUN)
  `SFR_ASSERT_NOW(a_ack_class, clk, rst_n, out_valid && ack_status, out_frame_class == CLS_ACK)
  `SFR_ASSERT_NEXT(a_stall_keeps_input, clk, rst_n, s1_valid && out_valid && !out_ready, s1_valid)
endmodule

// ----- src/sfr_in_stage.sv -----
// Input register of the serial frame receiver: holds one item for the parser.
// Depends on sfr_pkg.
module sfr_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfr_pkg::item_t in_item,
  input  logic          advance,
  output logic          s1_valid,
  output sfr_pkg::item_t s1_item
);
  import sfr_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

// ----- src/sfr_parser.sv -----
// Frame parser: phase register, XOR check lanes and header fields, one byte a cycle while fire is high.
// Depends on sfr_pkg.
module sfr_parser #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  sfr_pkg::item_t item,
  input  logic           ir_mode,
  output logic           emit,
  output sfr_pkg::res_t  res
);
  import sfr_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_FRAME_BYTES);

  logic [3:0]    phase_r, phase_nxt;
  logic [7:0]    even_r, even_nxt, odd_r, odd_nxt;
  logic          par_r, par_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic [7:0]    fn_r, fn_nxt, seq_r, seq_nxt;

  logic [7:0]  b;
  logic [7:0]  start_byte;
  logic        hunt;
  logic [17:0] lx, bcx, end_cnt;

  function automatic res_t mk_status(input logic [1:0] st, input logic [7:0] ty,
                                     input logic [15:0] ln, input logic [7:0] fnum,
                                     input logic [7:0] sq);
    res_t r;
    r = '0;
    r.record_kind      = REC_STATUS;
    r.frame_status     = st;
    r.frame_class      = (ty == TYPE_ACK) ? CLS_ACK :
                         (ty == TYPE_LINK) ? CLS_LINK : CLS_NORMAL;
    r.msg_code         = ty;
    r.body_length      = ln;
    r.frame_number     = fnum;
    r.sequence_low     = sq[3:0];
    r.first_of_message = sq[6];
    return r;
  endfunction

  assign b          = item.rx_data;
  assign start_byte = ir_mode ? START_IR : START_CABLE;
  assign lx         = {2'b00, len_r};
  assign bcx        = 18'(bc_r);
  assign end_cnt    = lx + 18'(len_r[0]) + 18'd2;

  always_comb begin
    phase_nxt = phase_r;
    even_nxt  = even_r;
    odd_nxt   = odd_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    bc_nxt    = bc_r;
    fn_nxt    = fn_r;
    seq_nxt   = seq_r;
    emit      = 1'b0;
    res       = '0;
    hunt      = 1'b0;

    if (par_r) begin
      odd_nxt = odd_r ^ b;
    end else begin
      even_nxt = even_r ^ b;
    end
    par_nxt = ~par_r;

    case (phase_r)
      PH_DEST: begin
        if (b == ADDR_PHONE) begin
          phase_nxt = PH_SRC;
        end else if (b == ADDR_HOST) begin
          phase_nxt = PH_ECHO_SRC;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_SRC: begin
        phase_nxt = (b == ADDR_HOST) ? PH_TYPE : PH_HUNT;
      end
      PH_TYPE: begin
        type_nxt  = b;
        phase_nxt = PH_LEN1;
      end
      PH_LEN1: begin
        len_nxt   = {b, 8'h00};
        phase_nxt = PH_LEN2;
      end
      PH_LEN2: begin
        len_nxt   = {len_r[15:8], b};
        bc_nxt    = '0;
        phase_nxt = PH_BODY;
      end
      PH_BODY: begin
        if (bc_r >= MAXC) begin
          phase_nxt = PH_HUNT;
          emit      = 1'b1;
          res       = mk_status(ST_OVERRUN, type_r, len_r, fn_r, seq_r);
        end else begin
          bc_nxt = bc_r + CW'(1);
          if (len_r >= 16'd2 && bcx == lx - 18'd2) begin
            fn_nxt = b;
          end
          if (len_r >= 16'd1 && bcx == lx - 18'd1) begin
            seq_nxt = b;
          end
          if (bcx + 18'd1 == end_cnt) begin
            phase_nxt = PH_HUNT;
            emit      = 1'b1;
            res       = mk_status((even_nxt == odd_nxt) ? ST_GOOD : ST_BAD,
                                  type_r, len_r, fn_nxt, seq_nxt);
          end else if (bcx < lx) begin
            emit              = 1'b1;
            res.record_kind   = REC_CONTENT;
            res.content_byte  = b;
            res.content_index = bcx[7:0];
          end
        end
      end
      PH_ECHO_SRC: begin
        phase_nxt = (b == ADDR_PHONE) ? PH_ECHO_TYPE : PH_HUNT;
      end
      PH_ECHO_TYPE: begin
        type_nxt  = b;
        phase_nxt = PH_ECHO_LEN1;
      end
      PH_ECHO_LEN1: begin
        phase_nxt = PH_ECHO_LEN2;
      end
      PH_ECHO_LEN2: begin
        len_nxt   = {8'h00, b};
        bc_nxt    = '0;
        phase_nxt = PH_ECHO_BODY;
      end
      PH_ECHO_BODY: begin
        if (bc_r >= MAXC) begin
          phase_nxt = PH_HUNT;
        end else begin
          bc_nxt = bc_r + CW'(1);
          if (bcx + 18'd1 == end_cnt) begin
            phase_nxt = PH_HUNT;
          end
        end
      end
      PH_DISCARD: begin
        hunt = item.gap_before;
      end
      default: begin
        hunt = 1'b1;
      end
    endcase

    if (hunt) begin
      if (b == start_byte) begin
        even_nxt  = b;
        odd_nxt   = 8'h00;
        par_nxt   = 1'b1;
        fn_nxt    = 8'h00;
        seq_nxt   = 8'h00;
        phase_nxt = PH_DEST;
      end else begin
        phase_nxt = PH_DISCARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      even_r  <= '0;
      odd_r   <= '0;
      par_r   <= 1'b0;
      type_r  <= '0;
      len_r   <= '0;
      bc_r    <= '0;
      fn_r    <= '0;
      seq_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      even_r  <= even_nxt;
      odd_r   <= odd_nxt;
      par_r   <= par_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      bc_r    <= bc_nxt;
      fn_r    <= fn_nxt;
      seq_r   <= seq_nxt;
    end
  end
endmodule

// ----- src/sfr_out_stage.sv -----
// Result register of the serial frame receiver.
// Depends on sfr_pkg.
module sfr_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  sfr_pkg::res_t res_in,
  input  logic          out_ready,
  output logic          out_valid,
  output sfr_pkg::res_t res_out
);
  import sfr_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;
endmodule

// ----- sim/sfr_frame_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for serial_frame_receiver_xor_check: watches the byte, result and ir_mode ports,
// predicts content and status records per accepted byte and compares them in order.
// Depends on sfr_pkg only.
module sfr_frame_checker #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_data,
  input  logic        in_gap_before,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_record_kind,
  input  logic [7:0]  out_content_byte,
  input  logic [7:0]  out_content_index,
  input  logic [1:0]  out_frame_status,
  input  logic [1:0]  out_frame_class,
  input  logic [7:0]  out_msg_code,
  input  logic [15:0] out_body_length,
  input  logic [7:0]  out_frame_number,
  input  logic [3:0]  out_sequence_low,
  input  logic        out_first_of_message,
  output int          fail_count,
  output int          pending
);
  import sfr_pkg::*;

  logic        ir_sel;
  logic [3:0]  phase;
  logic [7:0]  lane_even;
  logic [7:0]  lane_odd;
  logic        lane_toggle;
  logic [7:0]  hdr_type;
  logic [15:0] hdr_length;
  int          body_seen;
  logic [7:0]  seen_frame_number;
  logic [7:0]  seen_sequence;
  res_t        awaited_records[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic res_t status_record(input logic [1:0] st);
    res_t r;
    r = '0;
    r.record_kind = REC_STATUS;
    r.frame_status = st;
    r.frame_class = (hdr_type == TYPE_ACK) ? CLS_ACK :
                    (hdr_type == TYPE_LINK) ? CLS_LINK : CLS_NORMAL;
    r.msg_code = hdr_type;
    r.body_length = hdr_length;
    r.frame_number = seen_frame_number;
    r.sequence_low = seen_sequence[3:0];
    r.first_of_message = seen_sequence[6];
    return r;
  endfunction

  // advances the frame parser by one byte; returns 1 when a record is due
  function automatic bit parse_byte(input logic [7:0] b, input logic gap, output res_t r);
    int  len;
    int  idx;
    bit  hunt;
    bit  emit;
    r = '0;
    len = int'(hdr_length);
    hunt = 1'b0;
    emit = 1'b0;
    if (lane_toggle) lane_odd ^= b;
    else lane_even ^= b;
    lane_toggle = ~lane_toggle;
    case (phase)
      PH_DEST: phase = (b == ADDR_PHONE) ? PH_SRC : (b == ADDR_HOST) ? PH_ECHO_SRC : PH_HUNT;
      PH_SRC: phase = (b == ADDR_HOST) ? PH_TYPE : PH_HUNT;
      PH_TYPE: begin
        hdr_type = b;
        phase = PH_LEN1;
      end
      PH_LEN1: begin
        hdr_length = {b, 8'h00};
        phase = PH_LEN2;
      end
      PH_LEN2: begin
        hdr_length[7:0] = b;
        body_seen = 0;
        phase = PH_BODY;
      end
      PH_BODY: begin
        if (body_seen >= MAX_FRAME_BYTES) begin
          phase = PH_HUNT;
          r = status_record(ST_OVERRUN);
          emit = 1'b1;
        end else begin
          idx = body_seen;
          body_seen++;
          if (len >= 2 && idx == len - 2) seen_frame_number = b;
          if (len >= 1 && idx == len - 1) seen_sequence = b;
          if (body_seen == len + (len % 2) + 2) begin
            phase = PH_HUNT;
            r = status_record((lane_even == lane_odd) ? ST_GOOD : ST_BAD);
            emit = 1'b1;
          end else if (idx < len) begin
            r.record_kind = REC_CONTENT;
            r.content_byte = b;
            r.content_index = idx[7:0];
            emit = 1'b1;
          end
        end
      end
      PH_ECHO_SRC: phase = (b == ADDR_PHONE) ? PH_ECHO_TYPE : PH_HUNT;
      PH_ECHO_TYPE: begin
        hdr_type = b;
        phase = PH_ECHO_LEN1;
      end
      PH_ECHO_LEN1: phase = PH_ECHO_LEN2;
      PH_ECHO_LEN2: begin
        hdr_length = {8'h00, b};
        body_seen = 0;
        phase = PH_ECHO_BODY;
      end
      PH_ECHO_BODY: begin
        if (body_seen >= MAX_FRAME_BYTES) begin
          phase = PH_HUNT;
        end else begin
          body_seen++;
          if (body_seen == len + (len % 2) + 2) phase = PH_HUNT;
        end
      end
      PH_DISCARD: hunt = gap;
      default: hunt = 1'b1;
    endcase
    if (hunt) begin
      if (b == (ir_sel ? START_IR : START_CABLE)) begin
        lane_even = b;
        lane_odd = 8'h00;
        lane_toggle = 1'b1;
        seen_frame_number = 8'h00;
        seen_sequence = 8'h00;
        phase = PH_DEST;
      end else begin
        phase = PH_DISCARD;
      end
    end
    return emit;
  endfunction

  function automatic string rec_text(input res_t r);
    return {$sformatf("kind %0d byte %02h idx %0d status %0d class %0d ",
                      r.record_kind, r.content_byte, r.content_index, r.frame_status,
                      r.frame_class),
            $sformatf("type %02h len %0d num %02h seq %0h first %0d",
                      r.msg_code, r.body_length, r.frame_number,
                      r.sequence_low, r.first_of_message)};
  endfunction

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (!rst_n) begin
      ir_sel = 1'b0;
      phase = PH_HUNT;
      lane_even = 8'h00;
      lane_odd = 8'h00;
      lane_toggle = 1'b0;
      hdr_type = 8'h00;
      hdr_length = 16'h0000;
      body_seen = 0;
      seen_frame_number = 8'h00;
      seen_sequence = 8'h00;
      awaited_records.delete();
    end else begin
      if (cfg_wr_en) ir_sel = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = {out_record_kind, out_content_byte, out_content_index, out_frame_status,
               out_frame_class, out_msg_code, out_body_length, out_frame_number,
               out_sequence_low, out_first_of_message};
        if (awaited_records.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: record with none expected, got %s", $time, rec_text(got));
        end else begin
          want = awaited_records.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: record mismatch, expected %s, got %s", $time,
                       rec_text(want), rec_text(got));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (parse_byte(in_rx_data, in_gap_before, want)) awaited_records.push_back(want);
      end
    end
    pending = awaited_records.size();
  end

endmodule

// ----- sim/serial_frame_receiver_xor_check_tb.sv -----
`timescale 1ns / 1ps
// Top of the serial frame receiver testbench: clock, reset, ir_mode writes and byte stimulus
// built from well-formed, corrupted, echo and broken frames and random bytes.
// Depends on sfr_pkg, serial_frame_receiver_xor_check and sfr_frame_checker.
module serial_frame_receiver_xor_check_tb;
  import sfr_pkg::*;

  localparam int MAX_BYTES   = 256;
  localparam int ITEM_TARGET = 1750;
  localparam int QUIET_FROM  = 1500;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_data;
  logic        in_gap_before;
  logic        out_valid;
  logic        out_ready;
  logic        out_record_kind;
  logic [7:0]  out_content_byte;
  logic [7:0]  out_content_index;
  logic [1:0]  out_frame_status;
  logic [1:0]  out_frame_class;
  logic [7:0]  out_msg_code;
  logic [15:0] out_body_length;
  logic [7:0]  out_frame_number;
  logic [3:0]  out_sequence_low;
  logic        out_first_of_message;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          sent;
  bit          quiet;
  bit          hold_req;
  bit          start_gap;
  logic        ir_sel;
  int          frame_pos;
  logic [7:0]  frame_lane_even;
  logic [7:0]  frame_lane_odd;

  serial_frame_receiver_xor_check #(.MAX_FRAME_BYTES(MAX_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_data(in_rx_data), .in_gap_before(in_gap_before),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_record_kind(out_record_kind), .out_content_byte(out_content_byte),
    .out_content_index(out_content_index), .out_frame_status(out_frame_status),
    .out_frame_class(out_frame_class), .out_msg_code(out_msg_code),
    .out_body_length(out_body_length), .out_frame_number(out_frame_number),
    .out_sequence_low(out_sequence_low), .out_first_of_message(out_first_of_message)
  );

  sfr_frame_checker #(.MAX_FRAME_BYTES(MAX_BYTES)) frame_chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_data(in_rx_data), .in_gap_before(in_gap_before),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_record_kind(out_record_kind), .out_content_byte(out_content_byte),
    .out_content_index(out_content_index), .out_frame_status(out_frame_status),
    .out_frame_class(out_frame_class), .out_msg_code(out_msg_code),
    .out_body_length(out_body_length), .out_frame_number(out_frame_number),
    .out_sequence_low(out_sequence_low), .out_first_of_message(out_first_of_message),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL serial_frame_receiver_xor_check");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request, always ready when quiet
  initial begin
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic g);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_data <= b;
    in_gap_before <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_ir(input logic v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    ir_sel = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic open_frame();
    frame_pos = 1;
    frame_lane_even = ir_sel ? START_IR : START_CABLE;
    frame_lane_odd = 8'h00;
    send_item(frame_lane_even, start_gap);
  endtask

  task automatic frame_byte(input logic [7:0] b);
    if (frame_pos % 2) frame_lane_odd ^= b;
    else frame_lane_even ^= b;
    frame_pos++;
    send_item(b, $urandom_range(0, 7) == 0);
  endtask

  // lengths beyond the buffer get one body byte more than it holds
  task automatic send_frame(input logic [7:0] mtype, input int len, input bit corrupt);
    int         n;
    logic [7:0] c;
    n = len + (len % 2) + 2;
    open_frame();
    frame_byte(ADDR_PHONE);
    frame_byte(ADDR_HOST);
    frame_byte(mtype);
    frame_byte(len[15:8]);
    frame_byte(len[7:0]);
    if (n > MAX_BYTES) begin
      repeat (MAX_BYTES + 1) frame_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat (n - 2) frame_byte(8'($urandom_range(0, 255)));
      frame_byte(8'($urandom_range(0, 255)));
      c = frame_lane_even ^ frame_lane_odd;
      if (corrupt) c ^= 8'h01 << $urandom_range(0, 7);
      frame_byte(c);
    end
  endtask

  task automatic send_echo(input logic [7:0] len_lo);
    int n;
    n = int'(len_lo) + int'(len_lo[0]) + 2;
    open_frame();
    frame_byte(ADDR_HOST);
    frame_byte(ADDR_PHONE);
    frame_byte(8'($urandom_range(0, 255)));
    frame_byte(8'($urandom_range(0, 255)));
    frame_byte(len_lo);
    repeat ((n > MAX_BYTES) ? MAX_BYTES + 1 : n) frame_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == ADDR_PHONE) b = 8'h0d;
    case ($urandom_range(0, 3))
      0: begin
        open_frame();
        frame_byte(b);
      end
      1: begin
        open_frame();
        frame_byte(ADDR_PHONE);
        frame_byte(b);
      end
      2: begin
        open_frame();
        frame_byte(ADDR_HOST);
        frame_byte(b ^ ADDR_PHONE);
      end
      default: begin
        if ($urandom_range(0, 1))
          send_item(ir_sel ? START_CABLE : START_IR, 1'($urandom_range(0, 1)));
        else send_item(ir_sel ? START_IR : START_CABLE, 1'b0);
      end
    endcase
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 3))
      0: return TYPE_ACK;
      1: return TYPE_LINK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_traffic();
    int k;
    int len;
    k = $urandom_range(0, 99);
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
    if (k < 60) send_frame(pick_type(), len, 1'b0);
    else if (k < 70) send_frame(pick_type(), len, 1'b1);
    else if (k < 79) send_echo(8'($urandom_range(0, 20)));
    else if (k < 87) send_broken();
    else if (k < 95) begin
      repeat ($urandom_range(1, 6))
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    else if (k < 97) send_frame(pick_type(), $urandom_range(200, 254), $urandom_range(0, 3) == 0);
    else if (k < 98) send_echo(8'($urandom_range(200, 255)));
    else if (k < 99) send_frame(pick_type(), $urandom_range(255, 65535), 1'b0);
    else send_frame(pick_type(), 1, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int seg;
    int seg_end;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_rx_data = 8'h00;
    in_gap_before = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    start_gap = 1'b1;
    ir_sel = 1'b0;
    sent = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    write_ir(1'b0);
    send_frame(TYPE_ACK, 0, 1'b0);
    send_frame(TYPE_LINK, 1, 1'b1);
    send_frame(8'hff, 2, 1'b0);
    open_frame();
    frame_byte(8'hff);
    // restart straight after a bad destination, no gap
    start_gap = 1'b0;
    send_frame(8'h00, 3, 1'b0);
    start_gap = 1'b1;
    open_frame();
    frame_byte(ADDR_PHONE);
    frame_byte(8'h01);
    open_frame();
    frame_byte(ADDR_HOST);
    frame_byte(ADDR_HOST);
    send_echo(8'd1);
    send_item(8'hff, 1'b0);
    send_item(START_CABLE, 1'b0);
    send_item(START_IR, 1'b1);
    send_frame(8'h10, 4, 1'b0);
    write_ir(1'b1);
    send_frame(TYPE_ACK, 5, 1'b0);
    send_item(START_CABLE, 1'b1);
    send_frame(TYPE_LINK, 2, 1'b0);

    seg = 0;
    while (sent < ITEM_TARGET) begin
      write_ir(~ir_sel);
      if (seg == 1) begin
        hold_req = 1'b1;
        send_frame(pick_type(), 30, 1'b0);
      end
      if (seg == 2) begin
        send_frame(pick_type(), 254, 1'b0);
        send_frame(pick_type(), 65535, 1'b0);
        send_echo(8'd255);
      end
      seg_end = sent + 250;
      while (sent < seg_end && sent < ITEM_TARGET) begin
        quiet = (sent >= QUIET_FROM);
        send_random_traffic();
      end
      seg++;
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS serial_frame_receiver_xor_check");
    end else begin
      $display("FAIL serial_frame_receiver_xor_check");
    end
    $finish;
  end

endmodule
